@@ hw/rtl/npt_pkg.sv @@
// Shared types and constants of the nearest path point tracker.
package npt_pkg;

    localparam int MAX_POINTS = 2048;
    localparam int COORD_BITS = 24;
    localparam int RAD_W      = 23;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(102400);

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] nearest_index;
        logic             found;
    } t_out_item;

endpackage

@@ hw/rtl/npt_store.sv @@
// Path point memory: one write port and one registered read port for x and y.
module npt_store (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [npt_pkg::IDX_W-1:0]             i_waddr,
    input  logic signed [npt_pkg::COORD_BITS-1:0] i_wx,
    input  logic signed [npt_pkg::COORD_BITS-1:0] i_wy,
    input  logic [npt_pkg::IDX_W-1:0]             i_raddr,
    output logic signed [npt_pkg::COORD_BITS-1:0] o_rx,
    output logic signed [npt_pkg::COORD_BITS-1:0] o_ry
);

    logic signed [npt_pkg::COORD_BITS-1:0] r_mem_x [0:npt_pkg::MAX_POINTS-1];
    logic signed [npt_pkg::COORD_BITS-1:0] r_mem_y [0:npt_pkg::MAX_POINTS-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wx;
            r_mem_y[i_waddr] <= i_wy;
        end
        o_rx <= r_mem_x[i_raddr];
        o_ry <= r_mem_y[i_raddr];
    end

endmodule

@@ hw/rtl/npt_mul.sv @@
// Shared unsigned multiplier with a registered product, used for every square.
module npt_mul (
    input  logic                          i_clk,
    input  logic [npt_pkg::DIFF_W-1:0]    i_a,
    input  logic [npt_pkg::DIFF_W-1:0]    i_b,
    output logic [npt_pkg::PROD_W-1:0]    o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= npt_pkg::PROD_W'(i_a) * npt_pkg::PROD_W'(i_b);
    end

endmodule

@@ hw/rtl/nearest_path_point_tracker.sv @@
// Top level of the nearest path point tracker: command sequencer and scan datapath.
//
// Usage. A command is transferred at a rising edge where start is high and busy is low.
// Its action either appends a point (x, y) to the path, clears the path and the start
// index, or queries the path point nearest to the target (x, y). Appends and clears
// finish in the transfer cycle and give no result; an append to a full path is dropped.
// A query scans the stored points from the start index to the end of the path through
// one shared multiplier; for each point it forms the differences, squares x, squares y
// and compares. Busy stays high through a load step and the scan after the transfer,
// and the result appears on o_result, marked by o_done, in the cycle busy falls. The
// scan stops early at a point at distance zero; with no point left to scan the result
// follows in the cycle after the transfer. Each result is shown for exactly one cycle
// and the receiver cannot stall it. The search radius is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while idle, which the block does not enforce.
// Reset empties the path, zeroes the start index and restores the radius to 100.0 m;
// the point memory is not cleared, as only entries below the point count are ever read.
module nearest_path_point_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  npt_pkg::t_in_item                  i_cmd,
    output logic                               o_done,
    output npt_pkg::t_out_item                 o_result,
    input  logic                               i_cfg_we,
    input  logic [npt_pkg::RAD_W-1:0]          i_cfg_wdata
);

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_DIFF = 6'b000100,
        S_SQX  = 6'b001000,
        S_SQY  = 6'b010000,
        S_CMP  = 6'b100000
    } t_state;

    // Control state.
    t_state                         r_state,     n_state;
    logic [npt_pkg::CNT_W-1:0]      r_count,     n_count;
    logic [npt_pkg::IDX_W-1:0]      r_start_idx, n_start_idx;
    logic [npt_pkg::RAD_W-1:0]      r_radius,    n_radius;
    logic                           r_done,      n_done;

    // Scan datapath.
    logic signed [npt_pkg::COORD_BITS-1:0] r_tx, n_tx;
    logic signed [npt_pkg::COORD_BITS-1:0] r_ty, n_ty;
    logic [npt_pkg::CNT_W-1:0]      r_idx,      n_idx;
    logic [npt_pkg::IDX_W-1:0]      r_cur,      n_cur;
    logic [npt_pkg::DIFF_W-1:0]     r_dx,       n_dx;
    logic [npt_pkg::DIFF_W-1:0]     r_dy,       n_dy;
    logic [npt_pkg::PROD_W-1:0]     r_acc,      n_acc;
    logic [npt_pkg::PROD_W-1:0]     r_best,     n_best;
    logic [npt_pkg::IDX_W-1:0]      r_best_idx, n_best_idx;
    logic                           r_hit,      n_hit;
    npt_pkg::t_out_item             r_result,   n_result;

    logic                                  accept;
    logic                                  mem_we;
    logic signed [npt_pkg::COORD_BITS-1:0] rd_x;
    logic signed [npt_pkg::COORD_BITS-1:0] rd_y;
    logic [npt_pkg::DIFF_W-1:0]            mul_a;
    logic [npt_pkg::PROD_W-1:0]            prod;
    logic signed [npt_pkg::DIFF_W-1:0]     diff_x;
    logic signed [npt_pkg::DIFF_W-1:0]     diff_y;
    logic [npt_pkg::PROD_W-1:0]            dist_sq;
    logic                                  closer;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // Appends write the memory in the transfer cycle; full paths drop the point.
    assign mem_we = accept && (i_cmd.action == npt_pkg::ACT_APPEND)
                    && (r_count < npt_pkg::CNT_W'(npt_pkg::MAX_POINTS));

    npt_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[npt_pkg::IDX_W-1:0]),
        .i_wx    (i_cmd.coord_x),
        .i_wy    (i_cmd.coord_y),
        .i_raddr (r_idx[npt_pkg::IDX_W-1:0]),
        .o_rx    (rd_x),
        .o_ry    (rd_y)
    );

    // The multiplier squares the radius while idle, so the squared bound is
    // ready in the load cycle, then squares |dx| and |dy| of each point in turn.
    always_comb begin
        unique case (r_state)
            S_IDLE:  mul_a = npt_pkg::DIFF_W'(r_radius);
            S_SQY:   mul_a = r_dy;
            default: mul_a = r_dx;
        endcase
    end

    npt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_a),
        .o_p   (prod)
    );

    // Coordinate differences cannot exceed the saturation bound at this width,
    // so plain absolute values are exact.
    assign diff_x = npt_pkg::DIFF_W'(r_tx) - npt_pkg::DIFF_W'(rd_x);
    assign diff_y = npt_pkg::DIFF_W'(r_ty) - npt_pkg::DIFF_W'(rd_y);

    // In the compare cycle the product register holds dy squared.
    assign dist_sq = r_acc + prod;
    assign closer  = (dist_sq < r_best);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_start_idx = r_start_idx;
        n_radius    = r_radius;
        n_done      = 1'b0;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_acc       = r_acc;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_hit       = r_hit;
        n_result    = r_result;

        if (i_cfg_we) begin
            n_radius = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_cmd.action == npt_pkg::ACT_APPEND) begin
                        if (mem_we) begin
                            n_count = r_count + npt_pkg::CNT_W'(1);
                        end
                    end else if (i_cmd.action == npt_pkg::ACT_CLEAR) begin
                        n_count     = '0;
                        n_start_idx = '0;
                    end else if (i_cmd.action == npt_pkg::ACT_QUERY) begin
                        n_tx       = i_cmd.coord_x;
                        n_ty       = i_cmd.coord_y;
                        n_idx      = npt_pkg::CNT_W'(r_start_idx);
                        n_best_idx = r_start_idx;
                        n_hit      = 1'b0;
                        if (npt_pkg::CNT_W'(r_start_idx) < r_count) begin
                            n_state = S_LOAD;
                        end else begin
                            // Nothing left to scan: report the start index, not found.
                            n_done                 = 1'b1;
                            n_result.nearest_index = r_start_idx;
                            n_result.found         = 1'b0;
                        end
                    end else begin
                        // The unused action code is taken and ignored.
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOAD: begin
                n_best  = prod;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_dx    = diff_x[npt_pkg::DIFF_W-1] ? npt_pkg::DIFF_W'(-diff_x)
                                                    : npt_pkg::DIFF_W'(diff_x);
                n_dy    = diff_y[npt_pkg::DIFF_W-1] ? npt_pkg::DIFF_W'(-diff_y)
                                                    : npt_pkg::DIFF_W'(diff_y);
                n_cur   = r_idx[npt_pkg::IDX_W-1:0];
                n_idx   = r_idx + npt_pkg::CNT_W'(1);
                n_state = S_SQX;
            end
            S_SQX: begin
                n_state = S_SQY;
            end
            S_SQY: begin
                n_acc   = prod;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (closer) begin
                    n_best     = dist_sq;
                    n_best_idx = r_cur;
                    n_hit      = 1'b1;
                end
                if ((closer && (dist_sq == '0)) || (r_idx >= r_count)) begin
                    n_state                = S_IDLE;
                    n_done                 = 1'b1;
                    n_result.nearest_index = n_best_idx;
                    n_result.found         = n_hit;
                    if (n_hit) begin
                        n_start_idx = n_best_idx;
                    end
                end else begin
                    n_state = S_DIFF;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_start_idx <= '0;
            r_radius    <= npt_pkg::RADIUS_RESET;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_start_idx <= n_start_idx;
            r_radius    <= n_radius;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tx       <= n_tx;
        r_ty       <= n_ty;
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_acc      <= n_acc;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_hit      <= n_hit;
        r_result   <= n_result;
    end

endmodule

@@ dv/npt_path_checker.sv @@
// Checker for the nearest path point tracker: tracks the path, predicts each query result and compares it.
module npt_path_checker
    import npt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_in_item          i_cmd,
    input  logic              i_done,
    input  t_out_item         i_result,
    input  logic              i_cfg_we,
    input  logic [RAD_W-1:0]  i_cfg_wdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DIFF_CAP = 64'h8000_0000;

    logic signed [COORD_BITS-1:0] path_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] path_y [MAX_POINTS];
    logic [CNT_W-1:0]             path_len;
    logic [IDX_W-1:0]             scan_origin;
    logic [RAD_W-1:0]             radius;
    t_out_item                    expected_nearest [$];
    int                           fail_count = 0;
    int                           pending    = 0;
    int                           checked    = 0;
    int                           hits       = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_hits       = hits;

    // Scans from the remembered origin to the end of the path; the first point with the
    // least squared distance below the squared radius wins and becomes the new origin.
    function automatic t_out_item scan_for_nearest(input logic signed [COORD_BITS-1:0] tx,
                                                   input logic signed [COORD_BITS-1:0] ty);
        longint    best;
        longint    dist_sq;
        longint    dx;
        longint    dy;
        logic      hit;
        t_out_item res;
        best = longint'(radius) * longint'(radius);
        hit  = 1'b0;
        res.nearest_index = scan_origin;
        for (int i = int'(scan_origin); i < int'(path_len); i++) begin
            dx = longint'(tx) - longint'(path_x[i]);
            dy = longint'(ty) - longint'(path_y[i]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > DIFF_CAP) dx = DIFF_CAP;
            if (dy > DIFF_CAP) dy = DIFF_CAP;
            dist_sq = dx * dx + dy * dy;
            if (dist_sq < best) begin
                best              = dist_sq;
                res.nearest_index = IDX_W'(i);
                hit               = 1'b1;
                if (dist_sq == 0) break;
            end
        end
        res.found = hit;
        if (hit) scan_origin = res.nearest_index;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            path_len    = '0;
            scan_origin = '0;
            radius      = RADIUS_RESET;
            expected_nearest.delete();
        end else begin
            if (i_done) begin
                if (expected_nearest.size() == 0) begin
                    $display("%0t: result index %0d found %0b with no query outstanding",
                             $time, i_result.nearest_index, i_result.found);
                    fail_count++;
                end else begin
                    want = expected_nearest.pop_front();
                    checked++;
                    if (want.found) hits++;
                    if (i_result.nearest_index !== want.nearest_index) begin
                        $display("%0t: nearest_index expected %0d, actual %0d",
                                 $time, want.nearest_index, i_result.nearest_index);
                        fail_count++;
                    end
                    if (i_result.found !== want.found) begin
                        $display("%0t: found expected %0b, actual %0b",
                                 $time, want.found, i_result.found);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) radius = i_cfg_wdata;
            if (i_start && !i_busy) begin
                case (i_cmd.action)
                    ACT_APPEND: begin
                        if (path_len < CNT_W'(MAX_POINTS)) begin
                            path_x[int'(path_len)] = i_cmd.coord_x;
                            path_y[int'(path_len)] = i_cmd.coord_y;
                            path_len++;
                        end
                    end
                    ACT_QUERY: begin
                        expected_nearest.push_back(scan_for_nearest(i_cmd.coord_x,
                                                                    i_cmd.coord_y));
                    end
                    ACT_CLEAR: begin
                        path_len    = '0;
                        scan_origin = '0;
                    end
                    default: ;
                endcase
            end
        end
        pending = expected_nearest.size();
    end

endmodule

@@ dv/nearest_path_point_tracker_tb.sv @@
// Testbench top for the nearest path point tracker: command stimulus, radius writes and verdict.
module nearest_path_point_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import npt_pkg::*;

    localparam int         CLK_PERIOD    = 8;
    localparam int         GAP_MAX       = 9;
    localparam int         RANDOM_ITEMS  = 265;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_LIMIT   = 40000;
    // Action code 3 is left undefined by the block and must be ignored.
    localparam logic [1:0] ACT_IGNORED   = 2'd3;
    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_in_item         cmd         = '0;
    logic             done;
    t_out_item        result;
    logic             cfg_we      = 1'b0;
    logic [RAD_W-1:0] cfg_wdata   = '0;

    // Copy of busy taken at the falling edge, so that the stimulus can tell at a rising
    // edge whether a transfer happened there without racing the block's own update.
    logic             busy_seen   = 1'b0;

    int               fail_count;
    int               pending;
    int               checked;
    int               hits;

    // Stimulus bookkeeping: the points appended since the last clear are kept so that
    // queries can be aimed at the path, which is the only way to get hits.
    logic signed [COORD_BITS-1:0] trail_x [$];
    logic signed [COORD_BITS-1:0] trail_y [$];
    logic [RAD_W-1:0]             radius_now = RADIUS_RESET;
    logic                         burst      = 1'b0;
    int                           n_items    = 0;
    int                           n_append   = 0;
    int                           n_clear    = 0;
    int                           n_ignored  = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) busy_seen <= busy;

    nearest_path_point_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    npt_path_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input longint v);
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        return COORD_BITS'(v);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom);
    endfunction

    // Issues one command. The gap before it is drawn per item (none in burst stretches).
    // The task returns at the rising edge where the transfer took place with start still
    // high, so that a following command with no gap keeps start high without a glitch.
    task automatic send(input logic [1:0] act,
                        input logic signed [COORD_BITS-1:0] x,
                        input logic signed [COORD_BITS-1:0] y);
        int gap;
        gap = burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        cmd   <= '{action: act, coord_x: x, coord_y: y};
        do @(posedge i_clk); while (busy_seen);
        case (act)
            ACT_APPEND: begin
                n_append++;
                trail_x.push_back(x);
                trail_y.push_back(y);
            end
            ACT_CLEAR: begin
                n_clear++;
                trail_x.delete();
                trail_y.delete();
            end
            ACT_IGNORED: n_ignored++;
            default: ;
        endcase
        if (act != ACT_IGNORED) n_items++;
    endtask

    // Holds the sender off until every outstanding query has been answered and the block
    // has gone quiet, then lets a few more cycles pass for any work that gives no result.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The radius may only change while the block is idle.
    task automatic set_radius(input logic [RAD_W-1:0] r);
        drain();
        cfg_we     <= 1'b1;
        cfg_wdata  <= r;
        radius_now  = r;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
    endtask

    // Queries a target near one of the points on the current path, exactly on one, or
    // somewhere at random. Offsets are scaled to the radius so that hits and misses mix.
    task automatic query_near();
        int     k;
        longint span;
        longint ox;
        longint oy;
        logic signed [COORD_BITS-1:0] tx;
        logic signed [COORD_BITS-1:0] ty;
        span = longint'(radius_now) / 2;
        if (trail_x.size() == 0 || $urandom_range(0, 5) == 0) begin
            tx = rand_coord();
            ty = rand_coord();
        end else begin
            k = $urandom_range(0, trail_x.size() - 1);
            if ($urandom_range(0, 3) == 0) begin
                ox = 0;
                oy = 0;
            end else begin
                ox = longint'($urandom_range(0, int'(2 * span))) - span;
                oy = longint'($urandom_range(0, int'(2 * span))) - span;
            end
            tx = sat_coord(longint'(trail_x[k]) + ox);
            ty = sat_coord(longint'(trail_y[k]) + oy);
        end
        send(ACT_QUERY, tx, ty);
    endtask

    // Appends a short path as a random walk, now and then repeating the previous point
    // so that ties occur, and sprinkling in commands the block must ignore.
    task automatic append_walk(input int n);
        longint wx;
        longint wy;
        wx = longint'(rand_coord());
        wy = longint'(rand_coord());
        for (int i = 0; i < n; i++) begin
            if (i == 0 || $urandom_range(0, 7) != 0) begin
                wx = longint'(sat_coord(wx + int'($urandom_range(0, 6000)) - 3000));
                wy = longint'(sat_coord(wy + int'($urandom_range(0, 6000)) - 3000));
            end
            if ($urandom_range(0, 11) == 0) send(ACT_IGNORED, rand_coord(), rand_coord());
            send(ACT_APPEND, sat_coord(wx), sat_coord(wy));
        end
    endtask

    initial begin
        int                     waited;
        int                     n_queries;
        int                     random_goal;
        logic [RAD_W-1:0]       r;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset radius of 100 m first. A query on an empty path
        // must report nothing found at the start index.
        send(ACT_QUERY, 24'sd0, 24'sd0);
        send(ACT_APPEND, COORD_MIN, COORD_MIN);
        send(ACT_APPEND, COORD_MAX, COORD_MAX);
        send(ACT_APPEND, 24'sd1024, 24'sd0);
        send(ACT_APPEND, 24'sd0, 24'sd1024);
        send(ACT_IGNORED, 24'sd5, 24'sd5);
        // Two points 1 m away in different directions: the earlier one must win the tie.
        send(ACT_QUERY, 24'sd0, 24'sd0);
        // Opposite corners of the coordinate range: far beyond any radius.
        send(ACT_QUERY, COORD_MAX, COORD_MIN);
        send(ACT_APPEND, 24'sd0, 24'sd0);
        send(ACT_APPEND, 24'sd0, 24'sd0);
        // An exact match stops the scan at the first of the two identical points.
        send(ACT_QUERY, 24'sd0, 24'sd0);
        // The point at index 0 lies behind the start index and is no longer searched.
        send(ACT_QUERY, COORD_MIN, COORD_MIN);
        send(ACT_CLEAR, 24'sd0, 24'sd0);
        send(ACT_QUERY, 24'sd0, 24'sd0);
        send(ACT_APPEND, COORD_MAX, COORD_MAX);
        send(ACT_QUERY, COORD_MAX, COORD_MAX - 24'sd1);

        // Largest radius: the corners are still out of reach, the middle is not.
        set_radius(RAD_MAX);
        send(ACT_APPEND, COORD_MIN, COORD_MAX);
        send(ACT_QUERY, COORD_MAX, COORD_MIN);
        send(ACT_QUERY, 24'sd4194304, 24'sd4194304);

        // Radius zero accepts nothing, not even an exact match; radius one accepts it.
        set_radius('0);
        send(ACT_QUERY, COORD_MAX, COORD_MAX);
        set_radius(RAD_W'(1));
        send(ACT_QUERY, COORD_MAX, COORD_MAX);
        send(ACT_CLEAR, 24'sd0, 24'sd0);

        // Random part: short paths built as walks, then queries aimed at them, with the
        // radius changed between some segments and broken sequences mixed in.
        random_goal = n_items + RANDOM_ITEMS;
        while (n_items < random_goal) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       r = '0;
                    1:       r = RAD_W'(1);
                    2:       r = RADIUS_RESET;
                    3:       r = RAD_MAX;
                    4:       r = RAD_W'($urandom_range(1024, 65535));
                    default: r = RAD_W'($urandom_range(0, int'(RAD_MAX)));
                endcase
                set_radius(r);
            end
            if ($urandom_range(0, 3) != 0) send(ACT_CLEAR, rand_coord(), rand_coord());
            append_walk($urandom_range(1, 24));
            n_queries = $urandom_range(1, 6);
            for (int q = 0; q < n_queries; q++) begin
                case ($urandom_range(0, 19))
                    0, 1:    send(ACT_IGNORED, rand_coord(), rand_coord());
                    2, 3:    send(ACT_APPEND, rand_coord(), rand_coord());
                    4:       send(ACT_CLEAR, rand_coord(), rand_coord());
                    default: ;
                endcase
                query_near();
            end
            // Now and then the sender waits for every outstanding result before going on.
            if ($urandom_range(0, 4) == 0) drain();
        end

        // Wind down: wait for the last results, bounded, then a few more quiet cycles.
        start  <= 1'b0;
        waited  = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while ((pending != 0 || busy) && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d query results (%0d found a point) after %0d appends, %0d clears",
                 checked, hits, n_append, n_clear);
        $display("and %0d ignored commands, with radii from zero to full scale.",
                 n_ignored);
        if (pending != 0) $display("%0d query results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #(20_000_000);
        $display("Timed out with %0d query results outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ nearest_path_point_tracker.f @@
hw/rtl/npt_pkg.sv
hw/rtl/npt_store.sv
hw/rtl/npt_mul.sv
hw/rtl/nearest_path_point_tracker.sv
dv/npt_path_checker.sv
dv/nearest_path_point_tracker_tb.sv
